### rtl/core/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg
// Shared types and constants for the numeric literal scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package nls_pkg;

  // Longest literal length that is counted; the count holds there.
  localparam int MAX_LEN = 64;
  localparam int LEN_W   = 7;
  // Internal count wide enough to reach MAX_LEN; the result shows all of its bits
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  // Classification queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [1:0] {
    BC_DEC = 2'd0,
    BC_HEX = 2'd1,
    BC_BIN = 2'd2,
    BC_OCT = 2'd3
  } base_t;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_SIGNED  = 3'd1,
    PH_ZERO    = 3'd2,
    PH_MAIN    = 3'd3,
    PH_EXPSIGN = 3'd4,
    PH_EXPDIG  = 3'd5
  } phase_t;

  // Character classes as the scanner sees them
  typedef enum logic [3:0] {
    CC_MINUS = 4'd0,
    CC_PLUS  = 4'd1,
    CC_ZERO  = 4'd2,
    CC_ONE   = 4'd3,   // '1'
    CC_OCT   = 4'd4,   // '2'..'7'
    CC_DEC   = 4'd5,   // '8', '9'
    CC_HEX   = 4'd6,   // a-d, f and upper case, except b
    CC_B     = 4'd7,   // b or B: binary prefix or hex digit
    CC_E     = 4'd8,   // e or E: exponent or hex digit
    CC_X     = 4'd9,
    CC_DOT   = 4'd10,
    CC_OTHER = 4'd11
  } char_class_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } char_item_t;

  typedef struct packed {
    char_class_t cls;
    logic        end_of_text;
  } class_item_t;

  typedef struct packed {
    logic             consumed;
    logic             done_res;
    logic [1:0]       base_code;
    logic             negative;
    logic             is_float;
    logic             has_exponent;
    logic [LEN_W-1:0] literal_length;
  } result_item_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t k;
    k = CC_OTHER;
    if (c == CH_MINUS)                              k = CC_MINUS;
    else if (c == CH_PLUS)                          k = CC_PLUS;
    else if (c == CH_0)                             k = CC_ZERO;
    else if (c == CH_1)                             k = CC_ONE;
    else if (c > CH_1 && c <= CH_7)                 k = CC_OCT;
    else if (c > CH_7 && c <= CH_9)                 k = CC_DEC;
    else if (c == CH_LB || c == CH_UB)              k = CC_B;
    else if (c == CH_LE || c == CH_UE)              k = CC_E;
    else if (c == CH_LX || c == CH_UX)              k = CC_X;
    else if (c == CH_DOT)                           k = CC_DOT;
    else if ((c >= CH_LA && c <= CH_LD) || (c >= CH_UA && c <= CH_UD) ||
             c == CH_LF || c == CH_UF)              k = CC_HEX;
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/core/nls_front.sv
// ----------------------------------------------------------------------------
// nls_front
// Accepts characters, classifies them and registers the class for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  char_valid,
  output logic                 char_stall,
  input  nls_pkg::char_item_t  char_item,
  output logic                 cls_valid,
  input  wire                  cls_stall,
  output nls_pkg::class_item_t cls_item
);

  logic load;

  assign char_stall = cls_valid && cls_stall;
  assign load       = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (!char_stall) begin
      cls_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cls_item.cls         <= nls_pkg::classify(char_item.char_code);
      cls_item.end_of_text <= char_item.end_of_text;
    end
  end

endmodule

`default_nettype wire

### rtl/core/nls_queue.sv
// ----------------------------------------------------------------------------
// nls_queue
// Short FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push_valid,
  output logic                 push_stall,
  input  nls_pkg::class_item_t push_item,
  output logic                 pop_valid,
  input  wire                  pop_stall,
  output nls_pkg::class_item_t pop_item
);

  nls_pkg::class_item_t              slots [nls_pkg::QDEPTH];
  logic [nls_pkg::QPTR_W-1:0]        wr_ptr;
  logic [nls_pkg::QPTR_W-1:0]        rd_ptr;
  logic [nls_pkg::QCNT_W-1:0]        count;
  logic                              push;
  logic                              pop;

  assign push_stall = (count == nls_pkg::QCNT_W'(nls_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

### rtl/core/nls_back.sv
// ----------------------------------------------------------------------------
// nls_back
// Literal state machine: steps once per classified character and registers
// the result.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cls_valid,
  output logic                  cls_stall,
  input  nls_pkg::class_item_t  cls_item,
  output logic                  result_valid,
  input  wire                   result_stall,
  output nls_pkg::result_item_t result_item
);

  nls_pkg::phase_t           phase, phase_next;
  nls_pkg::base_t            base_reg, base_next;
  logic                      negative_reg, negative_next;
  logic                      float_reg, float_next;
  logic                      exponent_reg, exponent_next;
  logic [nls_pkg::CNT_W-1:0] length_count, length_next;
  logic                      took, fin;
  logic                      step;

  assign cls_stall = result_valid && result_stall;
  assign step      = cls_valid && !cls_stall;

  always_comb begin
    nls_pkg::char_class_t k;
    k             = cls_item.cls;
    took          = 1'b0;
    fin           = 1'b0;
    base_next     = base_reg;
    negative_next = negative_reg;
    float_next    = float_reg;
    exponent_next = exponent_reg;
    length_next   = length_count;

    unique case (phase)
      nls_pkg::PH_START, nls_pkg::PH_SIGNED, nls_pkg::PH_ZERO, nls_pkg::PH_MAIN,
      nls_pkg::PH_EXPSIGN, nls_pkg::PH_EXPDIG: phase_next = phase;
      default:                                 phase_next = nls_pkg::PH_START;
    endcase

    if (phase_next == nls_pkg::PH_START) begin
      if (k == nls_pkg::CC_MINUS) begin
        negative_next = 1'b1;
        took          = 1'b1;
      end else if (k == nls_pkg::CC_PLUS) begin
        took = 1'b1;
      end
      phase_next = nls_pkg::PH_SIGNED;
    end

    if (!took && phase_next == nls_pkg::PH_SIGNED) begin
      if (k == nls_pkg::CC_ZERO) begin
        took       = 1'b1;
        phase_next = nls_pkg::PH_ZERO;
      end else begin
        base_next  = nls_pkg::BC_DEC;
        phase_next = nls_pkg::PH_MAIN;
      end
    end

    if (!took && phase_next == nls_pkg::PH_ZERO) begin
      case (k) inside
        nls_pkg::CC_X: begin
          base_next  = nls_pkg::BC_HEX;
          took       = 1'b1;
          phase_next = nls_pkg::PH_MAIN;
        end
        nls_pkg::CC_B: begin
          base_next  = nls_pkg::BC_BIN;
          took       = 1'b1;
          phase_next = nls_pkg::PH_MAIN;
        end
        nls_pkg::CC_DOT: begin
          base_next  = nls_pkg::BC_DEC;
          float_next = 1'b1;
          took       = 1'b1;
          phase_next = nls_pkg::PH_MAIN;
        end
        // octal digit: rescanned below as the first octal digit
        nls_pkg::CC_ZERO, nls_pkg::CC_ONE, nls_pkg::CC_OCT: begin
          base_next  = nls_pkg::BC_OCT;
          phase_next = nls_pkg::PH_MAIN;
        end
        default: begin
          base_next = nls_pkg::BC_DEC;   // bare zero
          fin       = 1'b1;
        end
      endcase
    end

    if (!took && !fin && phase_next == nls_pkg::PH_MAIN) begin
      case (k) inside
        nls_pkg::CC_ZERO, nls_pkg::CC_ONE: took = 1'b1;
        nls_pkg::CC_OCT: begin
          if (base_next != nls_pkg::BC_BIN) took = 1'b1;
          else fin = 1'b1;
        end
        nls_pkg::CC_DEC: begin
          if (base_next == nls_pkg::BC_DEC || base_next == nls_pkg::BC_HEX) took = 1'b1;
          else fin = 1'b1;
        end
        nls_pkg::CC_HEX, nls_pkg::CC_B: begin
          if (base_next == nls_pkg::BC_HEX) took = 1'b1;
          else fin = 1'b1;
        end
        nls_pkg::CC_DOT: begin
          if (!float_next) begin
            float_next = 1'b1;
            took       = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        nls_pkg::CC_E: begin
          if (base_next == nls_pkg::BC_HEX) begin
            took = 1'b1;
          end else if (base_next == nls_pkg::BC_DEC) begin
            exponent_next = 1'b1;
            took          = 1'b1;
            phase_next    = nls_pkg::PH_EXPSIGN;
          end else begin
            fin = 1'b1;
          end
        end
        default: fin = 1'b1;
      endcase
    end

    if (!took && !fin && phase_next == nls_pkg::PH_EXPSIGN) begin
      if (k == nls_pkg::CC_PLUS || k == nls_pkg::CC_MINUS) took = 1'b1;
      phase_next = nls_pkg::PH_EXPDIG;
    end

    if (!took && !fin && phase_next == nls_pkg::PH_EXPDIG) begin
      case (k) inside
        nls_pkg::CC_ZERO, nls_pkg::CC_ONE, nls_pkg::CC_OCT, nls_pkg::CC_DEC: took = 1'b1;
        default: fin = 1'b1;
      endcase
    end

    if (took) begin
      if (length_count < nls_pkg::CNT_W'(nls_pkg::MAX_LEN)) begin
        length_next = length_count + 1'b1;
      end
      if (cls_item.end_of_text) fin = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= nls_pkg::PH_START;
      base_reg     <= nls_pkg::BC_DEC;
      negative_reg <= 1'b0;
      float_reg    <= 1'b0;
      exponent_reg <= 1'b0;
      length_count <= '0;
      result_valid <= 1'b0;
    end else begin
      if (!cls_stall) result_valid <= cls_valid;
      if (step) begin
        if (fin) begin
          // literal complete: next request starts a fresh one
          phase        <= nls_pkg::PH_START;
          base_reg     <= nls_pkg::BC_DEC;
          negative_reg <= 1'b0;
          float_reg    <= 1'b0;
          exponent_reg <= 1'b0;
          length_count <= '0;
        end else begin
          phase        <= phase_next;
          base_reg     <= base_next;
          negative_reg <= negative_next;
          float_reg    <= float_next;
          exponent_reg <= exponent_next;
          length_count <= length_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_item.consumed       <= took;
      result_item.done_res       <= fin;
      result_item.base_code      <= base_next;
      result_item.negative       <= negative_next;
      result_item.is_float       <= float_next;
      result_item.has_exponent   <= exponent_next;
      result_item.literal_length <= nls_pkg::LEN_W'(length_next);
    end
  end

endmodule

`default_nettype wire

### rtl/core/numeric_literal_scanner.sv
// ----------------------------------------------------------------------------
// numeric_literal_scanner
// Streaming recognizer for one numeric literal per run of characters.
// ----------------------------------------------------------------------------
// Takes one character per cycle and returns one result per character, in
// order, at a sustained rate of one per cycle when nothing stalls; a request
// passes the classify register, the queue and the state-machine result
// register on its way to a result. A four-entry queue between the classifier
// and the literal state machine absorbs stalls on the result side. The result
// flags and length describe the literal after that character; done_res marks
// its end; the ending character is reported as not consumed unless it is taken at end of text.
`default_nettype none

module numeric_literal_scanner (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   char_valid,
  output logic                  char_stall,
  input  nls_pkg::char_item_t   char_item,
  output logic                  result_valid,
  input  wire                   result_stall,
  output nls_pkg::result_item_t result_item
);

  logic                 f_valid, f_stall;
  nls_pkg::class_item_t f_item;
  logic                 q_valid, q_stall;
  nls_pkg::class_item_t q_item;

  nls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .cls_valid  (f_valid),
    .cls_stall  (f_stall),
    .cls_item   (f_item)
  );

  nls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_item   (q_item)
  );

  nls_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cls_valid    (q_valid),
    .cls_stall    (q_stall),
    .cls_item     (q_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

`default_nettype wire

### test/tb_numeric_literal_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_numeric_literal_scanner
// Streams characters into the scanner and checks every per-character result
// against a cycle-free predictor of the literal recognizer. A short directed
// pass covers prefixes, signs, floats, exponents and the corner cases; the
// bulk is random literals of every base with random content, plus noise,
// under random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------

module tb_numeric_literal_scanner;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {LF_DEC, LF_HEX, LF_BIN, LF_OCT, LF_ZDOT} lit_form_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  char_valid = 1'b0;
  logic                  char_stall;
  nls_pkg::char_item_t   char_item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  nls_pkg::result_item_t result_item;

  // predictor state
  nls_pkg::phase_t           sc_phase;
  nls_pkg::base_t            sc_base;
  logic                      sc_neg;
  logic                      sc_float;
  logic                      sc_exp;
  logic [nls_pkg::CNT_W-1:0] sc_len;

  nls_pkg::result_item_t expected_results[$];
  int n_accepted  = 0;
  int n_errors    = 0;
  int idle_cycles = 0;
  int rx_hold     = 0;
  bit tx_quiet    = 1'b0;
  bit rx_quiet    = 1'b0;

  numeric_literal_scanner u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_item    (char_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always #4 clk = ~clk;

  function automatic void reset_scan();
    sc_phase = nls_pkg::PH_START;
    sc_base  = nls_pkg::BC_DEC;
    sc_neg   = 1'b0;
    sc_float = 1'b0;
    sc_exp   = 1'b0;
    sc_len   = '0;
  endfunction

  // One character through the literal recognizer; returns the result for it.
  function automatic nls_pkg::result_item_t scan_char(input nls_pkg::char_item_t it);
    logic [7:0]            c;
    logic                  took;
    logic                  fin;
    nls_pkg::phase_t       ph;
    nls_pkg::result_item_t r;
    c    = it.char_code;
    took = 1'b0;
    fin  = 1'b0;
    ph   = sc_phase;
    if (ph == nls_pkg::PH_START) begin
      if (c == nls_pkg::CH_MINUS) begin
        sc_neg = 1'b1;
        took   = 1'b1;
      end else if (c == nls_pkg::CH_PLUS) begin
        took = 1'b1;
      end
      ph = nls_pkg::PH_SIGNED;
    end
    if (!took && ph == nls_pkg::PH_SIGNED) begin
      if (c == nls_pkg::CH_0) begin
        took = 1'b1;
        ph   = nls_pkg::PH_ZERO;
      end else begin
        sc_base = nls_pkg::BC_DEC;
        ph      = nls_pkg::PH_MAIN;
      end
    end
    if (!took && ph == nls_pkg::PH_ZERO) begin
      if (c == nls_pkg::CH_LX || c == nls_pkg::CH_UX) begin
        sc_base = nls_pkg::BC_HEX;
        took    = 1'b1;
        ph      = nls_pkg::PH_MAIN;
      end else if (c == nls_pkg::CH_LB || c == nls_pkg::CH_UB) begin
        sc_base = nls_pkg::BC_BIN;
        took    = 1'b1;
        ph      = nls_pkg::PH_MAIN;
      end else if (c == nls_pkg::CH_DOT) begin
        sc_base  = nls_pkg::BC_DEC;
        sc_float = 1'b1;
        took     = 1'b1;
        ph       = nls_pkg::PH_MAIN;
      end else if (c >= nls_pkg::CH_0 && c <= nls_pkg::CH_7) begin
        // octal digit is re-examined below as the first body digit
        sc_base = nls_pkg::BC_OCT;
        ph      = nls_pkg::PH_MAIN;
      end else begin
        sc_base = nls_pkg::BC_DEC;
        fin     = 1'b1;
      end
    end
    if (!took && !fin && ph == nls_pkg::PH_MAIN) begin
      if (c == nls_pkg::CH_0 || c == nls_pkg::CH_1) begin
        took = 1'b1;
      end else if (c > nls_pkg::CH_1 && c <= nls_pkg::CH_7) begin
        if (sc_base != nls_pkg::BC_BIN) took = 1'b1;
        else fin = 1'b1;
      end else if (c > nls_pkg::CH_7 && c <= nls_pkg::CH_9) begin
        if (sc_base == nls_pkg::BC_DEC || sc_base == nls_pkg::BC_HEX) took = 1'b1;
        else fin = 1'b1;
      end else if ((c >= nls_pkg::CH_LA && c <= nls_pkg::CH_LD) ||
                   (c >= nls_pkg::CH_UA && c <= nls_pkg::CH_UD) ||
                   c == nls_pkg::CH_LF || c == nls_pkg::CH_UF) begin
        if (sc_base == nls_pkg::BC_HEX) took = 1'b1;
        else fin = 1'b1;
      end else if (c == nls_pkg::CH_DOT) begin
        if (!sc_float) begin
          sc_float = 1'b1;
          took     = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end else if (c == nls_pkg::CH_LE || c == nls_pkg::CH_UE) begin
        if (sc_base == nls_pkg::BC_HEX) begin
          took = 1'b1;
        end else if (sc_base == nls_pkg::BC_DEC) begin
          sc_exp = 1'b1;
          took   = 1'b1;
          ph     = nls_pkg::PH_EXPSIGN;
        end else begin
          fin = 1'b1;
        end
      end else begin
        fin = 1'b1;
      end
    end
    if (!took && !fin && ph == nls_pkg::PH_EXPSIGN) begin
      if (c == nls_pkg::CH_PLUS || c == nls_pkg::CH_MINUS) took = 1'b1;
      ph = nls_pkg::PH_EXPDIG;
    end
    if (!took && !fin && ph == nls_pkg::PH_EXPDIG) begin
      if (c >= nls_pkg::CH_0 && c <= nls_pkg::CH_9) took = 1'b1;
      else fin = 1'b1;
    end
    if (took) begin
      if (sc_len < nls_pkg::MAX_LEN) sc_len = sc_len + 1'b1;
      if (it.end_of_text) fin = 1'b1;
    end
    sc_phase = ph;
    r.consumed       = took;
    r.done_res       = fin;
    r.base_code      = sc_base;
    r.negative       = sc_neg;
    r.is_float       = sc_float;
    r.has_exponent   = sc_exp;
    r.literal_length = nls_pkg::LEN_W'(sc_len);
    if (fin) reset_scan();
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic nls_pkg::char_item_t mk_char(input logic [7:0] c, input logic eot);
    nls_pkg::char_item_t it;
    it.char_code   = c;
    it.end_of_text = eot;
    return it;
  endfunction

  function automatic logic [7:0] pick_digit(input lit_form_t form);
    string hex_digits;
    hex_digits = "0123456789abcdefABCDEF";
    case (form)
      LF_HEX:  return hex_digits[$urandom_range(0, 21)];
      LF_BIN:  return nls_pkg::CH_0 + 8'($urandom_range(0, 1));
      LF_OCT:  return nls_pkg::CH_0 + 8'($urandom_range(0, 7));
      default: return nls_pkg::CH_0 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  task automatic send_char(input nls_pkg::char_item_t it);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item  <= it;
    do @(posedge clk); while (char_stall);
    expected_results = {expected_results, scan_char(it)};
    n_accepted++;
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++)
      send_char(mk_char(s[i], eot_last && (i == s.len() - 1)));
  endtask

  task automatic wait_drained();
    char_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [6:0] want,
                               input logic [6:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result(input nls_pkg::result_item_t got);
    nls_pkg::result_item_t want;
    if (expected_results.size() == 0) begin
      n_errors++;
      $display("%0t: result %h with no request pending", $time, got);
      return;
    end
    want = expected_results.pop_front();
    compare_field("consumed", want.consumed, got.consumed);
    compare_field("done_res", want.done_res, got.done_res);
    compare_field("base_code", want.base_code, got.base_code);
    compare_field("negative", want.negative, got.negative);
    compare_field("is_float", want.is_float, got.is_float);
    compare_field("has_exponent", want.has_exponent, got.has_exponent);
    compare_field("literal_length", want.literal_length, got.literal_length);
  endtask

  // Result side: check on accept, then stall at random.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_result(result_item);
    if ($urandom_range(0, 299) == 0) rx_quiet = !rx_quiet;
    if (rx_hold == 0 && !rx_quiet && $urandom_range(0, 2) == 0) rx_hold = pick_gap();
    if (rst) begin
      result_stall <= 1'b0;
    end else if (rx_hold > 0) begin
      result_stall <= 1'b1;
      rx_hold--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("numeric_literal_scanner: mismatch");
        $finish;
      end
    end
  end

  task automatic apply_reset();
    reset_scan();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_text("-0x1Fe", 1'b1);           // hex, minus, e as hex digit, text ends
    send_text("0B1", 1'b0);
    send_char(mk_char(8'hFF, 1'b0));     // binary ended by top byte
    send_text("07.9", 1'b0);             // octal float, 9 ends it
    send_text("0", 1'b0);
    send_char(mk_char(8'h00, 1'b0));     // bare zero ended by NUL
    send_char(mk_char(8'h80, 1'b0));     // empty literal
    send_text("+q", 1'b0);               // sign alone
    send_text("0.5.", 1'b0);             // second dot
    send_text("9E+", 1'b1);              // text ends right after exponent sign
    send_text("-", 1'b1);                // text ends after sign
  endtask

  task automatic send_random_literal();
    logic [7:0] txt[$];
    lit_form_t  form;
    int         ndig;
    case ($urandom_range(0, 3))
      0: txt = {txt, nls_pkg::CH_MINUS};
      1: txt = {txt, nls_pkg::CH_PLUS};
      default: ;
    endcase
    form = lit_form_t'($urandom_range(0, 4));
    case (form)
      LF_HEX: begin
        txt = {txt, nls_pkg::CH_0};
        txt = {txt, ($urandom_range(0, 1) ? nls_pkg::CH_LX : nls_pkg::CH_UX)};
      end
      LF_BIN: begin
        txt = {txt, nls_pkg::CH_0};
        txt = {txt, ($urandom_range(0, 1) ? nls_pkg::CH_LB : nls_pkg::CH_UB)};
      end
      LF_OCT: txt = {txt, nls_pkg::CH_0};
      LF_ZDOT: begin
        txt = {txt, nls_pkg::CH_0};
        txt = {txt, nls_pkg::CH_DOT};
      end
      default: ;
    endcase
    // now and then a body long enough to saturate the length count
    ndig = ($urandom_range(0, 49) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 6);
    repeat (ndig) txt = {txt, pick_digit(form)};
    if (form != LF_ZDOT && $urandom_range(0, 4) == 0) begin
      txt = {txt, nls_pkg::CH_DOT};
      repeat ($urandom_range(0, 4)) txt = {txt, pick_digit(form)};
    end
    if ((form == LF_DEC || form == LF_ZDOT) && $urandom_range(0, 3) == 0) begin
      txt = {txt, ($urandom_range(0, 1) ? nls_pkg::CH_LE : nls_pkg::CH_UE)};
      case ($urandom_range(0, 2))
        0: txt = {txt, nls_pkg::CH_MINUS};
        1: txt = {txt, nls_pkg::CH_PLUS};
        default: ;
      endcase
      repeat ($urandom_range(0, 3)) txt = {txt, pick_digit(LF_DEC)};
    end
    for (int i = 0; i < txt.size(); i++)
      send_char(mk_char(txt[i], 1'b0));
    if (txt.size() > 0 && $urandom_range(0, 2) == 0) begin
      send_char(mk_char(txt[$], 1'b1));
    end else if ($urandom_range(0, 4) == 0) begin
      send_char(mk_char(8'($urandom_range(0, 255)), 1'b0));
    end else begin
      case ($urandom_range(0, 3))
        0: send_char(mk_char(" ", 1'b0));
        1: send_char(mk_char(";", 1'b0));
        2: send_char(mk_char(",", 1'b0));
        default: send_char(mk_char(")", 1'b0));
      endcase
    end
  endtask

  task automatic test_random(input int target);
    while (n_accepted < target) begin
      if ($urandom_range(0, 29) == 0) tx_quiet = !tx_quiet;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3))
          send_char(mk_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0));
      end else begin
        send_random_literal();
      end
    end
  endtask

  initial begin
    apply_reset();
    test_directed();
    test_random(950);
    // hold requests until every pending result is back
    wait_drained();
    test_random(1850);
    wait_drained();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("numeric_literal_scanner: match");
    end else begin
      $display("numeric_literal_scanner: mismatch");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/nls_pkg.sv
rtl/core/nls_front.sv
rtl/core/nls_queue.sv
rtl/core/nls_back.sv
rtl/core/numeric_literal_scanner.sv
test/tb_numeric_literal_scanner.sv
